[src/eks_pkg.sv]
// ----------------------------------------------------------------------------
// eks_pkg
// Shared types and constants of the encoder and keypad setpoint entry block.
// ----------------------------------------------------------------------------
package eks_pkg;

  // message kinds
  typedef enum logic [1:0] {
    KIND_DISPLAY = 2'd0,
    KIND_REF     = 2'd1,
    KIND_UI      = 2'd2
  } kind_e;

  // ui message codes
  typedef enum logic [2:0] {
    UI_TYPING    = 3'd0,
    UI_FINE      = 3'd1,
    UI_SENT      = 3'd2,
    UI_STREAMING = 3'd3,
    UI_RESET     = 3'd4
  } ui_e;

  // input item kinds
  localparam logic ACT_ENCODER = 1'b0;
  localparam logic ACT_KEY     = 1'b1;

  // key codes
  localparam logic [3:0] KEY_SEND_BOTH  = 4'd0;
  localparam logic [3:0] KEY_PAN        = 4'd1;
  localparam logic [3:0] KEY_TILT       = 4'd2;
  localparam logic [3:0] KEY_STREAM_OFF = 4'd3;
  localparam logic [3:0] KEY_RESET      = 4'd9;
  localparam logic [3:0] KEY_STAR       = 4'd10;
  localparam logic [3:0] KEY_HASH       = 4'd11;

  // controller targets
  localparam logic [1:0] TGT_NONE = 2'd0;

  localparam logic [7:0] TYPING_DONE = 8'd17;
  localparam int unsigned COARSE_STEP = 10;

  // widths of the stream buses
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  // records held between the front and the back
  localparam int unsigned MAX_MSGS    = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    kind_e              kind;
    logic [1:0]         target;
    ui_e                ui_code;
    logic [7:0]         ui_data;
    logic signed [31:0] value;
  } msg_t;

  // a group of messages caused by one input item
  typedef struct packed {
    logic [1:0]                 cnt;
    msg_t [MAX_MSGS-1:0]        msg;
  } rec_t;

  // head of the queue as seen by the back
  typedef struct packed {
    logic valid;
    rec_t rec;
  } head_t;

endpackage

[src/eks_front.sv]
// ----------------------------------------------------------------------------
// eks_front
// Takes input items, updates the setpoint state and builds the group of
// messages that each item causes.
// ----------------------------------------------------------------------------
module eks_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               action_i,
  input  logic               pin_a_i,
  input  logic               pin_b_i,
  input  logic               pin_push_i,
  input  logic [3:0]         key_code_i,
  input  logic               key_is_push_i,
  input  logic               q_full_i,
  output logic               push_o,
  output eks_pkg::rec_t      rec_o
);
  import eks_pkg::*;

  logic signed [31:0] sp_q, sp_d;
  logic               prev_a_q, prev_a_d;
  logic               prev_push_q, prev_push_d;
  logic               coarse_q, coarse_d;
  logic [1:0]         stream_q, stream_d;
  logic               typing_q, typing_d;
  logic               neg_q, neg_d;
  logic [7:0]         count_q, count_d;

  logic               accept;
  logic signed [32:0] step;
  logic signed [32:0] step_sum;
  logic signed [31:0] sp_step;
  logic signed [35:0] times_ten;
  logic signed [35:0] digit_sum;
  logic signed [31:0] sp_digit;
  logic [1:0]         n;
  rec_t               rec;

  localparam logic signed [35:0] S32_MAX = 36'sh0_7FFF_FFFF;
  localparam logic signed [35:0] S32_MIN = -36'sh0_8000_0000;

  function automatic msg_t mk_show(logic signed [31:0] v);
    msg_t m;
    m = '0;
    m.kind  = KIND_DISPLAY;
    m.value = v;
    return m;
  endfunction

  function automatic msg_t mk_ref(logic [1:0] tgt, logic signed [31:0] v);
    msg_t m;
    m = '0;
    m.kind   = KIND_REF;
    m.target = tgt;
    m.value  = v;
    return m;
  endfunction

  function automatic msg_t mk_ui(ui_e code, logic [7:0] data);
    msg_t m;
    m = '0;
    m.kind    = KIND_UI;
    m.ui_code = code;
    m.ui_data = data;
    return m;
  endfunction

  function automatic logic signed [31:0] clamp36(logic signed [35:0] v);
    if (v > S32_MAX) begin
      return 32'sh7FFF_FFFF;
    end else if (v < S32_MIN) begin
      return -32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // encoder step, saturating
  always_comb begin
    step     = coarse_q ? 33'(COARSE_STEP) : 33'sd1;
    step_sum = (pin_a_i != pin_b_i) ? ({sp_q[31], sp_q} + step)
                                    : ({sp_q[31], sp_q} - step);
    sp_step  = clamp36(36'(step_sum));
  end

  // digit entry: value times ten plus or minus the digit, saturating
  always_comb begin
    times_ten = (36'(sp_q) <<< 3) + (36'(sp_q) <<< 1);
    digit_sum = neg_q ? (times_ten - 36'(key_code_i)) : (times_ten + 36'(key_code_i));
    sp_digit  = clamp36(digit_sum);
  end

  // classify the item, next state and message group
  always_comb begin
    sp_d        = sp_q;
    prev_a_d    = prev_a_q;
    prev_push_d = prev_push_q;
    coarse_d    = coarse_q;
    stream_d    = stream_q;
    typing_d    = typing_q;
    neg_d       = neg_q;
    count_d     = count_q;
    rec         = '0;
    n           = 2'd0;

    if (action_i == ACT_ENCODER) begin
      if (!typing_q) begin
        if (pin_a_i != prev_a_q) begin
          sp_d     = sp_step;
          prev_a_d = pin_a_i;
          if (stream_q != TGT_NONE) begin
            rec.msg[n] = mk_ref(stream_q, sp_step);
            n = n + 2'd1;
          end
          rec.msg[n] = mk_show(sp_step);
          n = n + 2'd1;
        end
        if (pin_push_i && !prev_push_q) begin
          coarse_d   = !coarse_q;
          rec.msg[n] = mk_ui(UI_FINE, {7'd0, coarse_q});
          n = n + 2'd1;
        end
        prev_push_d = pin_push_i;
      end
    end else if (typing_q) begin
      if (key_code_i != KEY_HASH) begin
        rec.msg[n] = mk_ui(UI_TYPING, count_q);
        n = n + 2'd1;
        count_d = count_q + 8'd1;
      end
      if (key_code_i <= KEY_RESET) begin
        sp_d = sp_digit;
      end else if (key_code_i == KEY_STAR) begin
        typing_d   = 1'b0;
        rec.msg[n] = mk_ui(UI_TYPING, TYPING_DONE);
        n = n + 2'd1;
      end else if (key_code_i == KEY_HASH) begin
        neg_d = !neg_q;
      end
      rec.msg[n] = mk_show(sp_d);
      n = n + 2'd1;
    end else begin
      unique case (key_code_i)
        KEY_HASH: begin
          sp_d       = '0;
          rec.msg[0] = mk_show('0);
          n          = 2'd1;
        end
        KEY_PAN, KEY_TILT: begin
          if (key_is_push_i) begin
            sp_d       = '0;
            rec.msg[0] = mk_ref(key_code_i[1:0], sp_q);
            rec.msg[1] = mk_show('0);
            rec.msg[2] = mk_ui(UI_SENT, {4'd0, key_code_i});
            n          = 2'd3;
          end else begin
            stream_d   = key_code_i[1:0];
            rec.msg[0] = mk_ui(UI_STREAMING, {4'd0, key_code_i});
            n          = 2'd1;
          end
        end
        KEY_STREAM_OFF: begin
          stream_d   = TGT_NONE;
          rec.msg[0] = mk_show(sp_q);
          rec.msg[1] = mk_ui(UI_STREAMING, 8'd0);
          n          = 2'd2;
        end
        KEY_RESET: begin
          rec.msg[0] = mk_ui(UI_RESET, 8'd0);
          n          = 2'd1;
        end
        KEY_SEND_BOTH: begin
          rec.msg[0] = mk_ref(TGT_NONE, sp_q);
          n          = 2'd1;
        end
        KEY_STAR: begin
          sp_d       = '0;
          typing_d   = 1'b1;
          neg_d      = 1'b0;
          count_d    = 8'd1;
          rec.msg[0] = mk_show('0);
          rec.msg[1] = mk_ui(UI_TYPING, 8'd0);
          rec.msg[2] = mk_ui(UI_TYPING, 8'd0);
          n          = 2'd3;
        end
        default: begin
        end
      endcase
    end
    rec.cnt = n;
  end

  assign push_o = accept && (n != 2'd0);
  assign rec_o  = rec;

  // setpoint state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q        <= '0;
      prev_a_q    <= 1'b0;
      prev_push_q <= 1'b0;
      coarse_q    <= 1'b0;
      stream_q    <= TGT_NONE;
      typing_q    <= 1'b0;
      neg_q       <= 1'b0;
      count_q     <= 8'd1;
    end else if (accept) begin
      sp_q        <= sp_d;
      prev_a_q    <= prev_a_d;
      prev_push_q <= prev_push_d;
      coarse_q    <= coarse_d;
      stream_q    <= stream_d;
      typing_q    <= typing_d;
      neg_q       <= neg_d;
      count_q     <= count_d;
    end
  end

endmodule

[src/eks_queue.sv]
// ----------------------------------------------------------------------------
// eks_queue
// Short queue of message groups between the front and the back.
// ----------------------------------------------------------------------------
module eks_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  eks_pkg::rec_t  rec_i,
  output logic           full_o,
  input  logic           pop_i,
  output eks_pkg::head_t head_o
);
  import eks_pkg::*;

  rec_t                entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_q, rd_q;
  logic [QCNT_W-1:0]   cnt_q;

  function automatic logic [QPTR_W-1:0] next_ptr(logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QPTR_W'(1);
  endfunction

  assign full_o          = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o.valid    = (cnt_q != '0);
  assign head_o.rec      = entry_q[rd_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= rec_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= next_ptr(wr_q);
      end
      if (pop_i) begin
        rd_q <= next_ptr(rd_q);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

[src/eks_back.sv]
// ----------------------------------------------------------------------------
// eks_back
// Sends the messages of each queued group one by one through an output
// register, marking the last one of the group.
// ----------------------------------------------------------------------------
module eks_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  eks_pkg::head_t head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output eks_pkg::msg_t  out_msg_o,
  output logic           out_last_o
);
  import eks_pkg::*;

  logic [1:0] slot_q;
  logic       out_valid_q;
  msg_t       out_msg_q;
  logic       out_last_q;
  logic       load;
  logic       is_last;

  assign load    = head_i.valid && (!out_valid_q || out_ready_i);
  assign is_last = (slot_q == (head_i.rec.cnt - 2'd1));
  assign pop_o   = load && is_last;

  // slot counter and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        slot_q      <= is_last ? 2'd0 : slot_q + 2'd1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_msg_q  <= head_i.rec.msg[slot_q];
      out_last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_msg_o   = out_msg_q;
  assign out_last_o  = out_last_q;

endmodule

[src/encoder_keypad_setpoint_entry.sv]
// ----------------------------------------------------------------------------
// encoder_keypad_setpoint_entry
// Setpoint entry from encoder pin samples and keypad events, with display,
// controller reference and ui messages as results.
//
//  channel  dir  tvalid/tready  tdata                          tuser     tlast
//  s_axis   in   request        a, b, push, key[3:0], is_push  action    -
//  m_axis   out  request        target, ui_code, ui_data, val  msg_kind  last
//
// The front takes one item per cycle and updates the setpoint in that cycle.
// An item causes zero to three messages; the back sends one message per
// cycle from a two-group queue while the receiver is ready. The front
// stalls only while the queue is full.
// Reset clears the control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module encoder_keypad_setpoint_entry (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // pin_a, pin_b, pin_push, key_code[3:0], key_is_push
  input  logic [eks_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // action
  input  logic                            s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // target[1:0], ui_code[2:0], ui_data[7:0], value_out[31:0], zero pad
  output logic [eks_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // msg_kind[1:0]
  output logic [1:0]                      m_axis_tuser_o,
  output logic                            m_axis_tlast_o
);
  import eks_pkg::*;

  logic  push;
  logic  full;
  logic  pop;
  rec_t  rec;
  head_t head;
  msg_t  out_msg;

  eks_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .action_i      (s_axis_tuser_i),
    .pin_a_i       (s_axis_tdata_i[0]),
    .pin_b_i       (s_axis_tdata_i[1]),
    .pin_push_i    (s_axis_tdata_i[2]),
    .key_code_i    (s_axis_tdata_i[6:3]),
    .key_is_push_i (s_axis_tdata_i[7]),
    .q_full_i      (full),
    .push_o        (push),
    .rec_o         (rec)
  );

  eks_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .rec_i  (rec),
    .full_o (full),
    .pop_i  (pop),
    .head_o (head)
  );

  eks_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_msg_o   (out_msg),
    .out_last_o  (m_axis_tlast_o)
  );

  // result bus packing
  assign m_axis_tuser_o = out_msg.kind;
  assign m_axis_tdata_o = {3'd0, out_msg.value, out_msg.ui_data, out_msg.ui_code,
                           out_msg.target};

endmodule

[dv/encoder_keypad_setpoint_entry_tb.sv]
// ----------------------------------------------------------------------------
// encoder_keypad_setpoint_entry_tb
// Self-checking bench for the encoder and keypad setpoint entry block. Every
// accepted request updates a setpoint tracker that queues the display,
// controller and ui messages it should cause. Each message leaving the block
// is checked field by field against the oldest queued one. The stimulus is a
// short directed pass, then quadrature walks, typing sessions (one of them
// long), single keys and noise. It runs with
// bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module encoder_keypad_setpoint_entry_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eks_pkg::*;

  localparam int unsigned TARGET_ITEMS = 410;
  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned LONG_SESSION = 270;
  localparam int unsigned MAX_PRINTS   = 40;
  localparam longint      S32_MAX      = 64'sd2147483647;
  localparam longint      S32_MIN      = -64'sd2147483648;
  localparam longint      DECIMAL_BASE = 10;
  localparam logic [3:0]  LAST_DIGIT   = 4'd9;
  localparam logic [3:0]  SPARE_LO     = 4'd4;
  localparam logic [3:0]  SPARE_HI     = 4'd8;
  localparam logic [3:0]  BAD_LO       = 4'd12;
  localparam logic [3:0]  BAD_HI       = 4'd15;

  // one expected message and its end-of-request flag
  typedef struct packed {
    msg_t msg;
    logic last;
  } out_msg_t;

  // tracks the setpoint state and queues the messages each request causes
  class setpoint_tracker;
    longint      setpoint;
    logic        prev_a;
    logic        prev_push;
    logic        coarse;
    logic        typing_mode;
    logic        negative;
    logic [1:0]  stream_tgt;
    logic [7:0]  typed_cnt;
    out_msg_t    pending_msgs[$];
    out_msg_t    item_msgs[$];
    int unsigned errors;

    function new();
      setpoint    = 0;
      prev_a      = 1'b0;
      prev_push   = 1'b0;
      coarse      = 1'b0;
      typing_mode = 1'b0;
      negative    = 1'b0;
      stream_tgt  = TGT_NONE;
      typed_cnt   = 8'd1;
      errors      = 0;
    endfunction

    function automatic longint clamp_s32(longint v);
      if (v > S32_MAX) return S32_MAX;
      if (v < S32_MIN) return S32_MIN;
      return v;
    endfunction

    // ui fields read zero on display and controller messages, value on ui
    function void add_msg(kind_e k, logic [1:0] tgt, ui_e code, logic [7:0] data);
      out_msg_t m;
      m.msg.kind    = k;
      m.msg.target  = tgt;
      m.msg.ui_code = code;
      m.msg.ui_data = data;
      m.msg.value   = (k == KIND_UI) ? 32'sd0 : setpoint[31:0];
      m.last        = 1'b0;
      item_msgs.push_back(m);
    endfunction

    function void show();
      add_msg(KIND_DISPLAY, TGT_NONE, UI_TYPING, 8'd0);
    endfunction

    function void typing_key(logic [3:0] key);
      longint d;
      d = longint'(key);
      if (key != KEY_HASH) begin
        add_msg(KIND_UI, TGT_NONE, UI_TYPING, typed_cnt);
        typed_cnt = typed_cnt + 8'd1;
      end
      if (key <= LAST_DIGIT) begin
        setpoint = clamp_s32(setpoint * DECIMAL_BASE + (negative ? -d : d));
      end else if (key == KEY_STAR) begin
        typing_mode = 1'b0;
        add_msg(KIND_UI, TGT_NONE, UI_TYPING, TYPING_DONE);
      end else if (key == KEY_HASH) begin
        negative = !negative;
      end
      show();
    endfunction

    function void normal_key(logic [3:0] key, logic is_push);
      case (key)
        KEY_HASH: begin
          setpoint = 0;
          show();
        end
        KEY_PAN, KEY_TILT: begin
          if (is_push) begin
            add_msg(KIND_REF, key[1:0], UI_TYPING, 8'd0);
            setpoint = 0;
            show();
            add_msg(KIND_UI, TGT_NONE, UI_SENT, {4'd0, key});
          end else begin
            stream_tgt = key[1:0];
            add_msg(KIND_UI, TGT_NONE, UI_STREAMING, {4'd0, key});
          end
        end
        KEY_STREAM_OFF: begin
          stream_tgt = TGT_NONE;
          show();
          add_msg(KIND_UI, TGT_NONE, UI_STREAMING, 8'd0);
        end
        KEY_RESET: add_msg(KIND_UI, TGT_NONE, UI_RESET, 8'd0);
        KEY_SEND_BOTH: add_msg(KIND_REF, TGT_NONE, UI_TYPING, 8'd0);
        KEY_STAR: begin
          setpoint = 0;
          show();
          add_msg(KIND_UI, TGT_NONE, UI_TYPING, 8'd0);
          add_msg(KIND_UI, TGT_NONE, UI_TYPING, 8'd0);
          typing_mode = 1'b1;
          negative    = 1'b0;
          typed_cnt   = 8'd1;
        end
        default: ;
      endcase
    endfunction

    // returns whether the request did anything at all
    function bit note_request(logic act, logic [7:0] data);
      logic a, b, p, is_push;
      logic [3:0] key;
      bit effective;
      longint step;
      a       = data[0];
      b       = data[1];
      p       = data[2];
      key     = data[6:3];
      is_push = data[7];
      effective = 1'b0;
      item_msgs.delete();
      if (act == ACT_ENCODER) begin
        if (!typing_mode) begin
          effective = (p != prev_push);
          if (a != prev_a) begin
            step     = coarse ? longint'(COARSE_STEP) : 1;
            setpoint = clamp_s32((a != b) ? setpoint + step : setpoint - step);
            prev_a   = a;
            if (stream_tgt != TGT_NONE) add_msg(KIND_REF, stream_tgt, UI_TYPING, 8'd0);
            show();
          end
          if (p && !prev_push) begin
            coarse = !coarse;
            add_msg(KIND_UI, TGT_NONE, UI_FINE, {7'd0, !coarse});
          end
          prev_push = p;
        end
      end else if (typing_mode) begin
        typing_key(key);
      end else begin
        normal_key(key, is_push);
      end
      if (item_msgs.size() != 0) begin
        item_msgs[item_msgs.size() - 1].last = 1'b1;
        effective = 1'b1;
      end
      foreach (item_msgs[i]) pending_msgs.push_back(item_msgs[i]);
      return effective;
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= MAX_PRINTS)
        $display("%0t error: %s got %0h want %0h", $time, what, got, want);
    endtask

    task check_message(logic [OUT_TDATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
      out_msg_t e;
      if (pending_msgs.size() == 0) begin
        report_mismatch("message with none pending, kind", 32'(tuser), 32'd0);
        return;
      end
      e = pending_msgs.pop_front();
      if (tuser !== e.msg.kind) report_mismatch("msg_kind", 32'(tuser), 32'(e.msg.kind));
      if (tdata[1:0] !== e.msg.target)
        report_mismatch("target", 32'(tdata[1:0]), 32'(e.msg.target));
      if (tdata[4:2] !== e.msg.ui_code)
        report_mismatch("ui_code", 32'(tdata[4:2]), 32'(e.msg.ui_code));
      if (tdata[12:5] !== e.msg.ui_data)
        report_mismatch("ui_data", 32'(tdata[12:5]), 32'(e.msg.ui_data));
      if (tdata[44:13] !== e.msg.value)
        report_mismatch("value_out", tdata[44:13], e.msg.value);
      if (tdata[47:45] !== 3'd0) report_mismatch("tdata pad", 32'(tdata[47:45]), 32'd0);
      if (tlast !== e.last) report_mismatch("tlast", 32'(tlast), 32'(e.last));
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i;
  logic                   s_axis_tuser_i;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [1:0]             m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  setpoint_tracker tracker;
  int unsigned     applied_items;
  int unsigned     burst_left;
  int unsigned     cycle_count;
  logic            cur_a, cur_b, cur_push;

  encoder_keypad_setpoint_entry dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // note accepted requests, then check accepted messages
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        void'(tracker.note_request(s_axis_tuser_i, s_axis_tdata_i));
        applied_items++;
      end
      if (m_axis_tvalid_o && m_axis_tready_i)
        tracker.check_message(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    end
  end

  // receiver stalls: free running, random, or a repeating mask
  always @(negedge clk_i) begin : receiver
    static int unsigned mode_left = 0;
    static int unsigned mode = 0;
    static int unsigned phase = 0;
    static logic [15:0] stall_mask = 16'hFFFF;
    if (mode_left == 0) begin
      mode       = $urandom_range(0, 2);
      mode_left  = $urandom_range(20, 120);
      stall_mask = 16'($urandom()) | 16'h0001;
    end
    mode_left--;
    phase++;
    case (mode)
      0:       m_axis_tready_i <= 1'b1;
      1:       m_axis_tready_i <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready_i <= stall_mask[phase % 16];
    endcase
  end

  // one request, with bursts and gaps; returns at the falling edge after it
  task automatic send_item(logic act, logic [7:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                : $urandom_range(1, 10);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= act;
    do @(posedge clk_i); while (!s_axis_tready_o);
    burst_left--;
    @(negedge clk_i);
    if (burst_left == 0) s_axis_tvalid_i <= 1'b0;
  endtask

  // key fields are don't-care on pin samples and the other way round
  task automatic send_enc(logic a, logic b, logic p);
    cur_a    = a;
    cur_b    = b;
    cur_push = p;
    send_item(ACT_ENCODER, {1'($urandom()), 4'($urandom()), p, b, a});
  endtask

  task automatic send_key(logic [3:0] key, logic is_push);
    send_item(ACT_KEY, {is_push, key, 3'($urandom())});
  endtask

  task automatic leave_typing();
    if (tracker.typing_mode) send_key(KEY_STAR, 1'($urandom()));
  endtask

  // quadrature walk with direction changes, push presses and glitches
  task automatic encoder_walk();
    int unsigned n;
    bit up;
    n  = $urandom_range(4, 24);
    up = 1'($urandom());
    leave_typing();
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) up = !up;
      if ($urandom_range(0, 6) == 0) cur_push = !cur_push;
      if ($urandom_range(0, 9) == 0) begin
        cur_a = 1'($urandom());
        cur_b = 1'($urandom());
      end else if ((cur_a == cur_b) == up) begin
        cur_a = !cur_a;
      end else begin
        cur_b = !cur_b;
      end
      send_enc(cur_a, cur_b, cur_push);
    end
  endtask

  // one key while typing: mostly digits, some sign flips, bad codes, pins
  task automatic typing_entry();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 75)      send_key(4'($urandom_range(0, LAST_DIGIT)), 1'($urandom()));
    else if (pick < 83) send_key(KEY_HASH, 1'($urandom()));
    else if (pick < 90) send_key(4'($urandom_range(BAD_LO, BAD_HI)), 1'($urandom()));
    else                send_enc(1'($urandom()), 1'($urandom()), 1'($urandom()));
  endtask

  task automatic typing_session(int unsigned n, bit finish_it);
    if (!tracker.typing_mode) send_key(KEY_STAR, 1'($urandom()));
    repeat (n) typing_entry();
    if (finish_it) send_key(KEY_STAR, 1'($urandom()));
  endtask

  // directed pass: steps both ways, coarse mode, streaming, every key
  task automatic directed_pass();
    send_enc(1'b1, 1'b0, 1'b0);
    send_enc(1'b0, 1'b0, 1'b0);
    send_enc(1'b0, 1'b0, 1'b1);
    send_enc(1'b1, 1'b1, 1'b1);
    send_enc(1'b0, 1'b1, 1'b0);
    send_key(KEY_PAN, 1'b0);
    send_enc(1'b1, 1'b1, 1'b1);
    send_key(KEY_TILT, 1'b0);
    send_enc(1'b0, 1'b1, 1'b0);
    send_key(KEY_PAN, 1'b1);
    send_key(KEY_TILT, 1'b1);
    send_key(KEY_STREAM_OFF, 1'b1);
    send_key(KEY_SEND_BOTH, 1'b1);
    send_key(KEY_RESET, 1'b0);
    send_key(SPARE_LO, 1'b1);
    send_key(BAD_HI, 1'b0);
    send_key(KEY_HASH, 1'b0);
    send_key(KEY_STAR, 1'b1);
    send_enc(1'b1, 1'b0, 1'b1);
    send_key(4'd7, 1'b1);
    send_key(KEY_HASH, 1'b1);
    send_key(4'd3, 1'b0);
    send_key(BAD_LO, 1'b1);
    send_key(KEY_STAR, 1'b0);
    send_enc(1'b1, 1'b0, 1'b0);
  endtask

  initial begin
    bit long_done;
    int unsigned pick;
    tracker         = new();
    applied_items   = 0;
    burst_left      = 0;
    cycle_count     = 0;
    long_done       = 1'b0;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = ACT_ENCODER;
    m_axis_tready_i = 1'b0;
    cur_a           = 1'b0;
    cur_b           = 1'b0;
    cur_push        = 1'b0;

    // reset
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_pass();

    // random mix until enough requests were sent
    while (applied_items < TARGET_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (!long_done && applied_items > TARGET_ITEMS / 3) begin
        // one long typing session
        long_done = 1'b1;
        typing_session(LONG_SESSION, 1'b1);
      end else if (pick < 35) begin
        typing_session($urandom_range(0, 12), $urandom_range(0, 99) < 85);
      end else if (pick < 70) begin
        encoder_walk();
      end else if (pick < 90) begin
        send_key(4'($urandom_range(0, BAD_HI)), 1'($urandom()));
      end else begin
        send_item(1'($urandom()), 8'($urandom()));
      end
    end
    if (s_axis_tvalid_i) s_axis_tvalid_i <= 1'b0;

    // drain, then give stray messages a chance to show up
    while (tracker.pending_msgs.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (tracker.errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
src/eks_pkg.sv
src/eks_front.sv
src/eks_queue.sv
src/eks_back.sv
src/encoder_keypad_setpoint_entry.sv
dv/encoder_keypad_setpoint_entry_tb.sv
